// ----- src/sobd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Speed, odometer and battery display package
// Shared types, segment codes and the digit to segment encoder.
// ----------------------------------------------------------------------------
package sobd_pkg;

    typedef logic [3:0] digit_t;
    typedef logic [6:0] seg_t;

    typedef struct packed {
        digit_t hundreds;
        digit_t tens;
        digit_t units;
    } bcd3_t;

    typedef struct packed {
        seg_t tens;
        seg_t units;
    } seg_pair_t;

    // Configuration register indexes.
    localparam logic CFG_ALARM_THRESHOLD = 1'b0;
    localparam logic CFG_KM_DISTANCE     = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int THRESH_W   = 9;
    localparam int KM_DIST_W  = 16;

    localparam logic [THRESH_W-1:0]  ALARM_THRESHOLD_RESET = 9'd40;
    localparam logic [KM_DIST_W-1:0] KM_DISTANCE_RESET     = 16'd1000;

    // Status patterns for the battery pair, active low, a in bit 6.
    localparam seg_t SEG_LO_TENS    = 7'h71;
    localparam seg_t SEG_LO_UNITS   = 7'h62;
    localparam seg_t SEG_FULL_TENS  = 7'h38;
    localparam seg_t SEG_FULL_UNITS = 7'h71;
    localparam seg_t SEG_BLANK      = 7'h7F;

    localparam logic [8:0] VOLTS_LOW_MAX  = 9'd41;
    localparam logic [8:0] VOLTS_FULL_MIN = 9'd52;
    localparam logic [8:0] VOLTS_PCT_BASE = 9'd42;

    function automatic seg_t digit_seg(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h01;
            4'd1:    s = 7'h4F;
            4'd2:    s = 7'h12;
            4'd3:    s = 7'h06;
            4'd4:    s = 7'h4C;
            4'd5:    s = 7'h24;
            4'd6:    s = 7'h20;
            4'd7:    s = 7'h0F;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h04;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- src/sobd_battery.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Battery display logic
// Turns the converter code into volts, the battery digit pair and the alarm.
// ----------------------------------------------------------------------------
module sobd_battery (
    input  wire logic [7:0]                    adc_code,
    input  wire logic                          dvm_mode,
    input  wire logic [sobd_pkg::THRESH_W-1:0] alarm_threshold,
    output sobd_pkg::seg_pair_t                segs,
    output logic                               alarm
);
    import sobd_pkg::*;

    logic [8:0]  volts;
    logic [16:0] volts_x205;
    logic [5:0]  volts_div10;
    logic [9:0]  q_x13;
    logic [2:0]  q_div10;
    logic [8:0]  units_full;
    logic [5:0]  tens_full;
    logic [8:0]  pct_off;
    digit_t      v_tens;
    digit_t      v_units;
    digit_t      pct_digit;

    assign volts = {adc_code, 1'b0};

    // Divide by ten through a reciprocal multiply; exact for every 9 bit volts value.
    assign volts_x205  = 17'(volts) * 17'd205;
    assign volts_div10 = volts_x205[16:11];
    assign units_full  = volts - 9'(volts_div10) * 9'd10;
    assign v_units     = units_full[3:0];

    assign q_x13     = 10'(volts_div10) * 10'd13;
    assign q_div10   = q_x13[9:7];
    assign tens_full = volts_div10 - 6'(q_div10) * 6'd10;
    assign v_tens    = tens_full[3:0];

    // Between the low and full marks the percentage is 11 times the offset,
    // so both of its digits equal the offset itself.
    assign pct_off   = volts - VOLTS_PCT_BASE;
    assign pct_digit = pct_off[3:0];

    always_comb
    begin
        if (!dvm_mode)
        begin
            segs.tens  = digit_seg(v_tens);
            segs.units = digit_seg(v_units);
        end
        else if (volts <= VOLTS_LOW_MAX)
        begin
            segs.tens  = SEG_LO_TENS;
            segs.units = SEG_LO_UNITS;
        end
        else if (volts >= VOLTS_FULL_MIN)
        begin
            segs.tens  = SEG_FULL_TENS;
            segs.units = SEG_FULL_UNITS;
        end
        else
        begin
            segs.tens  = digit_seg(pct_digit);
            segs.units = digit_seg(pct_digit);
        end
    end

    assign alarm = (volts <= alarm_threshold);

endmodule
`default_nettype wire

// ----- src/sobd_speed.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Speed digits
// Scales the pulse count by 2.7 and splits the speed into decimal digits.
// ----------------------------------------------------------------------------
module sobd_speed (
    input  wire logic [7:0] pulse_count,
    output sobd_pkg::bcd3_t digits
);
    import sobd_pkg::*;

    logic [25:0] scaled;
    logic [9:0]  speed;
    logic [14:0] speed_x41;
    logic [2:0]  hundreds;
    logic [9:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] rem_x205;
    digit_t      tens;
    logic [6:0]  units_full;

    // 27/10 folded into one multiply by 27 * 6554 and a 16 bit shift.
    assign scaled = 26'(pulse_count) * 26'd176958;
    assign speed  = scaled[25:16];

    assign speed_x41 = 15'(speed) * 15'd41;
    assign hundreds  = speed_x41[14:12];
    assign rem_full  = speed - 10'(hundreds) * 10'd100;
    assign rem       = rem_full[6:0];

    assign rem_x205   = 15'(rem) * 15'd205;
    assign tens       = rem_x205[14:11];
    assign units_full = rem - 7'(tens) * 7'd10;

    assign digits.hundreds = 4'(hundreds);
    assign digits.tens     = tens;
    assign digits.units    = units_full[3:0];

endmodule
`default_nettype wire

// ----- src/sobd_odometer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Odometer
// Accumulates distance per period and counts kilometres, with a decimal copy
// of the low three digits of the kilometre count.
// ----------------------------------------------------------------------------
module sobd_odometer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [7:0]                     pulse_count,
    input  wire logic [sobd_pkg::KM_DIST_W-1:0] km_distance,
    output sobd_pkg::bcd3_t                     km_digits_next
);
    import sobd_pkg::*;

    logic [15:0] distance_acc_reg;
    logic [15:0] distance_acc_next;
    logic [15:0] km_count_reg;
    logic [15:0] km_count_next;
    bcd3_t       km_bcd_reg;
    bcd3_t       km_bcd_next;
    bcd3_t       km_bcd_inc;
    logic [11:0] pulse_x9;
    logic [9:0]  distance_inc;
    logic [16:0] sum;
    logic        roll;

    assign pulse_x9     = 12'(pulse_count) * 12'd9;
    assign distance_inc = pulse_x9[11:2];
    assign sum          = 17'(distance_acc_reg) + 17'(distance_inc);
    assign roll         = (sum >= 17'(km_distance));

    always_comb
    begin
        km_bcd_inc = km_bcd_reg;
        if (km_bcd_reg.units != 4'd9)
        begin
            km_bcd_inc.units = km_bcd_reg.units + 4'd1;
        end
        else
        begin
            km_bcd_inc.units = 4'd0;
            if (km_bcd_reg.tens != 4'd9)
            begin
                km_bcd_inc.tens = km_bcd_reg.tens + 4'd1;
            end
            else
            begin
                km_bcd_inc.tens = 4'd0;
                if (km_bcd_reg.hundreds != 4'd9)
                begin
                    km_bcd_inc.hundreds = km_bcd_reg.hundreds + 4'd1;
                end
                else
                begin
                    km_bcd_inc.hundreds = 4'd0;
                end
            end
        end
    end

    always_comb
    begin
        distance_acc_next = distance_acc_reg;
        km_count_next     = km_count_reg;
        km_bcd_next       = km_bcd_reg;
        if (step)
        begin
            if (roll)
            begin
                distance_acc_next = '0;
                km_count_next     = km_count_reg + 16'd1;
                // The binary count wraps at 65536, where the low decimal
                // digits restart from zero rather than following on.
                if (km_count_reg == 16'hFFFF)
                begin
                    km_bcd_next = '0;
                end
                else
                begin
                    km_bcd_next = km_bcd_inc;
                end
            end
            else
            begin
                distance_acc_next = sum[15:0];
            end
        end
    end

    assign km_digits_next = km_bcd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_acc_reg <= '0;
            km_count_reg     <= '0;
            km_bcd_reg       <= '0;
        end
        else
        begin
            distance_acc_reg <= distance_acc_next;
            km_count_reg     <= km_count_next;
            km_bcd_reg       <= km_bcd_next;
        end
    end

`ifndef ASSERT_OFF
    a_acc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (distance_acc_reg < $past(km_distance)) || (distance_acc_reg == 16'd0))
        else $error("distance accumulator left at or above the kilometre distance");

    a_bcd_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (km_bcd_reg.units <= 4'd9) && (km_bcd_reg.tens <= 4'd9)
        && (km_bcd_reg.hundreds <= 4'd9))
        else $error("kilometre decimal digit out of range");

    a_count_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(km_bcd_reg) && $stable(km_count_reg)
        && $stable(distance_acc_reg))
        else $error("odometer state changed without a step");
`endif

endmodule
`default_nettype wire

// ----- src/speed_odometer_battery_display_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Speed, odometer and battery display core
// Input register, single pass of display logic, result register.
// ----------------------------------------------------------------------------
// One word is taken per measurement period and produces one result word of
// eight active-low seven-segment digits plus the battery alarm. The core
// accepts a word every clock cycle while in_stall is low. A word is held in
// the input register and then moves into the result register, whose contents
// are presented at the output. The odometer state is updated as the word
// moves into the result register. The result register lets a new word enter
// while the previous result is still stalled; input stall rises only when
// both registers are full and the output is stalled. Configuration writes
// take effect at the next clock edge and should only be made while the core
// is empty.
module speed_odometer_battery_display_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [sobd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      adc_code,
    input  wire logic [7:0]                      pulse_count,
    input  wire logic                            dvm_mode,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output sobd_pkg::seg_t                       battery_tens_seg,
    output sobd_pkg::seg_t                       battery_units_seg,
    output sobd_pkg::seg_t                       speed_hundreds_seg,
    output sobd_pkg::seg_t                       speed_tens_seg,
    output sobd_pkg::seg_t                       speed_units_seg,
    output sobd_pkg::seg_t                       km_hundreds_seg,
    output sobd_pkg::seg_t                       km_tens_seg,
    output sobd_pkg::seg_t                       km_units_seg,
    output logic                                 alarm
);
    import sobd_pkg::*;

    typedef struct packed {
        seg_pair_t battery;
        seg_t      speed_hundreds;
        seg_t      speed_tens;
        seg_t      speed_units;
        seg_t      km_hundreds;
        seg_t      km_tens;
        seg_t      km_units;
        logic      alarm;
    } result_t;

    logic [THRESH_W-1:0]  alarm_threshold_reg;
    logic [KM_DIST_W-1:0] km_distance_reg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] adc_code_reg;
    logic [7:0] pulse_count_reg;
    logic       dvm_mode_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;

    logic       accept_in;
    logic       advance;

    seg_pair_t  battery_segs;
    logic       alarm_now;
    bcd3_t      speed_digits;
    bcd3_t      km_digits;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_threshold_reg <= ALARM_THRESHOLD_RESET;
            km_distance_reg     <= KM_DISTANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALARM_THRESHOLD: alarm_threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_KM_DISTANCE:     km_distance_reg     <= cfg_data[KM_DIST_W-1:0];
                default:             ;
            endcase
        end
    end

    // The input word moves on whenever the result register is free or drains.
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && out_valid_reg && out_stall;
    assign accept_in      = in_valid && !in_stall;
    assign in_valid_next  = accept_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            adc_code_reg    <= adc_code;
            pulse_count_reg <= pulse_count;
            dvm_mode_reg    <= dvm_mode;
        end
    end

    sobd_battery u_battery (
        .adc_code        (adc_code_reg),
        .dvm_mode        (dvm_mode_reg),
        .alarm_threshold (alarm_threshold_reg),
        .segs            (battery_segs),
        .alarm           (alarm_now)
    );

    sobd_speed u_speed (
        .pulse_count (pulse_count_reg),
        .digits      (speed_digits)
    );

    sobd_odometer u_odometer (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .pulse_count    (pulse_count_reg),
        .km_distance    (km_distance_reg),
        .km_digits_next (km_digits)
    );

    always_comb
    begin
        result_next.battery        = battery_segs;
        result_next.speed_hundreds = digit_seg(speed_digits.hundreds);
        result_next.speed_tens     = digit_seg(speed_digits.tens);
        result_next.speed_units    = digit_seg(speed_digits.units);
        result_next.km_hundreds    = digit_seg(km_digits.hundreds);
        result_next.km_tens        = digit_seg(km_digits.tens);
        result_next.km_units       = digit_seg(km_digits.units);
        result_next.alarm          = alarm_now;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign battery_tens_seg   = result_reg.battery.tens;
    assign battery_units_seg  = result_reg.battery.units;
    assign speed_hundreds_seg = result_reg.speed_hundreds;
    assign speed_tens_seg     = result_reg.speed_tens;
    assign speed_units_seg    = result_reg.speed_units;
    assign km_hundreds_seg    = result_reg.km_hundreds;
    assign km_tens_seg        = result_reg.km_tens;
    assign km_units_seg       = result_reg.km_units;
    assign alarm              = result_reg.alarm;

`ifndef ASSERT_OFF
    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> in_valid_reg)
        else $error("accepted word did not reach the input register");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("word moved on but no result is presented");

    a_drain_empties_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !in_valid_reg |=> !out_valid_reg)
        else $error("result repeated after it was taken");
`endif

endmodule
`default_nettype wire

// ----- tb/speed_odometer_battery_display_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed, odometer and battery display core testbench
// Drives measurement words through the valid/stall input channel and checks
// every display word against a cycle-free model of the battery, speed and
// odometer logic. Phases change the alarm threshold and the kilometre length,
// vary idling on both sides, hold the output off to fill the core, and count
// a kilometre on every word with a zero kilometre length.
// ----------------------------------------------------------------------------
module speed_odometer_battery_display_core_tb;
    import sobd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [7:0] adc;
        logic [7:0] pulses;
        logic       mode;
    } word_t;

    typedef struct packed {
        seg_t bat_tens;
        seg_t bat_units;
        seg_t spd_hundreds;
        seg_t spd_tens;
        seg_t spd_units;
        seg_t km_hundreds;
        seg_t km_tens;
        seg_t km_units;
        logic alarm;
    } display_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_ALARM_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            adc_code = '0;
    logic [7:0]            pulse_count = '0;
    logic                  dvm_mode = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    seg_t                  battery_tens_seg;
    seg_t                  battery_units_seg;
    seg_t                  speed_hundreds_seg;
    seg_t                  speed_tens_seg;
    seg_t                  speed_units_seg;
    seg_t                  km_hundreds_seg;
    seg_t                  km_tens_seg;
    seg_t                  km_units_seg;
    logic                  alarm;

    // Words waiting to be driven and displays waiting to come out.
    word_t    word_q[$];
    display_t display_q[$];

    // Model copy of the registers and the odometer.
    logic [THRESH_W-1:0]  thr_reg = ALARM_THRESHOLD_RESET;
    logic [KM_DIST_W-1:0] km_len_reg = KM_DISTANCE_RESET;
    int                   odo_acc = 0;
    logic [15:0]          odo_km = '0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  sender_hold = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_count = 0;
    int  failures = 0;
    int  words_sent = 0;
    int  displays_checked = 0;
    int  reg_writes = 0;
    int  pct_words = 0;
    int  km_rollovers = 0;
    int  quiet_cycles = 0;

    speed_odometer_battery_display_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .adc_code           (adc_code),
        .pulse_count        (pulse_count),
        .dvm_mode           (dvm_mode),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .battery_tens_seg   (battery_tens_seg),
        .battery_units_seg  (battery_units_seg),
        .speed_hundreds_seg (speed_hundreds_seg),
        .speed_tens_seg     (speed_tens_seg),
        .speed_units_seg    (speed_units_seg),
        .km_hundreds_seg    (km_hundreds_seg),
        .km_tens_seg        (km_tens_seg),
        .km_units_seg       (km_units_seg),
        .alarm              (alarm)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic seg_t seg_of(input int value, input int div);
        case ((value / div) % 10)
            0:       return 7'h01;
            1:       return 7'h4F;
            2:       return 7'h12;
            3:       return 7'h06;
            4:       return 7'h4C;
            5:       return 7'h24;
            6:       return 7'h20;
            7:       return 7'h0F;
            8:       return 7'h00;
            default: return 7'h04;
        endcase
    endfunction

    // Works out the display for one word and advances the odometer copy.
    function automatic display_t predict_display(input word_t w);
        display_t d;
        int       volts;
        int       pct;
        int       speed;
        int       dist_sum;
        volts = 2 * int'(w.adc);
        if (!w.mode) begin
            d.bat_tens  = seg_of(volts, 10);
            d.bat_units = seg_of(volts, 1);
        end else if (volts <= int'(VOLTS_LOW_MAX)) begin
            d.bat_tens  = SEG_LO_TENS;
            d.bat_units = SEG_LO_UNITS;
        end else if (volts >= int'(VOLTS_FULL_MIN)) begin
            d.bat_tens  = SEG_FULL_TENS;
            d.bat_units = SEG_FULL_UNITS;
        end else begin
            pct = (volts - int'(VOLTS_PCT_BASE)) * 111 / 10;
            d.bat_tens  = seg_of(pct, 10);
            d.bat_units = seg_of(pct, 1);
            pct_words++;
        end
        dist_sum = odo_acc + int'(w.pulses) * 9 / 4;
        if (dist_sum >= int'(km_len_reg)) begin
            odo_acc = 0;
            if (odo_km == 16'hFFFF)
                km_rollovers++;
            odo_km = odo_km + 16'd1;
        end else begin
            odo_acc = dist_sum;
        end
        speed = int'(w.pulses) * 27 / 10;
        d.spd_hundreds = seg_of(speed, 100);
        d.spd_tens     = seg_of(speed, 10);
        d.spd_units    = seg_of(speed, 1);
        d.km_hundreds  = seg_of(int'(odo_km), 100);
        d.km_tens      = seg_of(int'(odo_km), 10);
        d.km_units     = seg_of(int'(odo_km), 1);
        d.alarm        = (volts <= int'(thr_reg));
        return d;
    endfunction

    // Random word, biased toward the percent band and the field extremes.
    function automatic word_t random_word();
        word_t w;
        case ($urandom_range(9))
            0, 1:    w.adc = 8'($urandom_range(28, 18));
            2:       w.adc = $urandom_range(1) ? 8'hFF : 8'h00;
            default: w.adc = 8'($urandom);
        endcase
        if ($urandom_range(15) == 0)
            w.pulses = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            w.pulses = 8'($urandom);
        w.mode = 1'($urandom);
        return w;
    endfunction

    task automatic check_field(input string name, input seg_t want, input seg_t got);
        if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic push_word(input logic [7:0] adc, input logic [7:0] pulses,
                             input logic mode);
        word_t w;
        w.adc    = adc;
        w.pulses = pulses;
        w.mode   = mode;
        word_q.push_back(w);
    endtask

    // Registers are written only while the core is empty.
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ALARM_THRESHOLD)
            thr_reg = val[THRESH_W-1:0];
        else
            km_len_reg = val;
        reg_writes++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (in_valid || display_q.size() != 0 || (!sender_hold && word_q.size() != 0));
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input bit hold, input bit mid_pause);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        long_hold_req  = hold;
        for (int i = 0; i < count; i++)
            word_q.push_back(random_word());
        if (mid_pause) begin
            while (word_q.size() > count / 2)
                @(negedge clk);
            sender_hold = 1'b1;
            wait_idle();
            sender_hold = 1'b0;
        end
        wait_idle();
    endtask

    // Driver: a stalled word stays put; otherwise offer the next one or idle.
    always @(posedge clk)
    begin : drive_proc
        word_t w;
        if (rst_n && (!in_valid || !in_stall)) begin
            if (word_q.size() != 0 && !sender_hold && $urandom_range(99) >= send_idle_pct) begin
                w = word_q.pop_front();
                in_valid    <= 1'b1;
                adc_code    <= w.adc;
                pulse_count <= w.pulses;
                dvm_mode    <= w.mode;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks the display word leaving, predicts the one entering.
    always @(posedge clk)
    begin : watch_proc
        display_t want;
        word_t    w;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (display_q.size() == 0) begin
                    failures++;
                    $display("%0t ns: display word with none expected, expected none, actual %h",
                             $time, {battery_tens_seg, battery_units_seg, speed_hundreds_seg,
                             speed_tens_seg, speed_units_seg, km_hundreds_seg, km_tens_seg,
                             km_units_seg, alarm});
                end else begin
                    want = display_q.pop_front();
                    check_field("battery_tens_seg", want.bat_tens, battery_tens_seg);
                    check_field("battery_units_seg", want.bat_units, battery_units_seg);
                    check_field("speed_hundreds_seg", want.spd_hundreds, speed_hundreds_seg);
                    check_field("speed_tens_seg", want.spd_tens, speed_tens_seg);
                    check_field("speed_units_seg", want.spd_units, speed_units_seg);
                    check_field("km_hundreds_seg", want.km_hundreds, km_hundreds_seg);
                    check_field("km_tens_seg", want.km_tens, km_tens_seg);
                    check_field("km_units_seg", want.km_units, km_units_seg);
                    check_field("alarm", {6'b0, want.alarm}, {6'b0, alarm});
                    displays_checked++;
                end
            end
            if (in_valid && !in_stall) begin
                w.adc    = adc_code;
                w.pulses = pulse_count;
                w.mode   = dvm_mode;
                display_q.push_back(predict_display(w));
                words_sent++;
            end
            // The long hold lets the sender keep offering until the core backs up.
            if (long_hold_req && !hold_done) begin
                out_stall <= 1'b1;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                    hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset register values.
        @(negedge clk);
        push_word(8'd0, 8'd0, 1'b0);
        push_word(8'd255, 8'd255, 1'b0);
        push_word(8'd255, 8'd255, 1'b1);
        push_word(8'd0, 8'd0, 1'b1);
        push_word(8'd20, 8'd1, 1'b1);
        push_word(8'd21, 8'd2, 1'b1);
        push_word(8'd22, 8'd3, 1'b1);
        push_word(8'd23, 8'd4, 1'b1);
        push_word(8'd24, 8'd5, 1'b1);
        push_word(8'd25, 8'd6, 1'b1);
        push_word(8'd26, 8'd7, 1'b1);
        push_word(8'd50, 8'd100, 1'b0);
        push_word(8'd19, 8'd37, 1'b0);
        push_word(8'd20, 8'd200, 1'b0);
        push_word(8'd21, 8'd250, 1'b0);
        push_word(8'd128, 8'd128, 1'b0);
        push_word(8'd170, 8'd85, 1'b1);
        push_word(8'd85, 8'd170, 1'b0);
        wait_idle();

        // Build up distance, then shrink the kilometre below the accumulator.
        write_reg(CFG_KM_DISTANCE, 16'd65535);
        @(negedge clk);
        for (int i = 0; i < 5; i++)
            push_word(8'($urandom), 8'd255, 1'($urandom));
        wait_idle();
        write_reg(CFG_KM_DISTANCE, 16'd100);
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            word_q.push_back(random_word());
        wait_idle();

        write_reg(CFG_ALARM_THRESHOLD, 16'd511);
        write_reg(CFG_KM_DISTANCE, 16'd1);
        run_phase(150, 85, 0, 1'b0, 1'b0);

        write_reg(CFG_ALARM_THRESHOLD, 16'd0);
        write_reg(CFG_KM_DISTANCE, 16'd65535);
        run_phase(200, 0, 85, 1'b1, 1'b0);

        write_reg(CFG_ALARM_THRESHOLD, 16'($urandom_range(200, 40)));
        write_reg(CFG_KM_DISTANCE, 16'($urandom_range(600, 100)));
        run_phase(200, 13, 13, 1'b0, 1'b1);

        // A zero kilometre counts one on every word.
        write_reg(CFG_ALARM_THRESHOLD, 16'($urandom_range(511)));
        write_reg(CFG_KM_DISTANCE, 16'd0);
        run_phase(75, 0, 0, 1'b0, 1'b0);

        write_reg(CFG_ALARM_THRESHOLD, 16'($urandom_range(511)));
        write_reg(CFG_KM_DISTANCE, 16'($urandom_range(3000, 1)));
        run_phase(400, 30, 30, 1'b0, 1'b0);

        wait_idle();
        repeat (4) @(negedge clk);
        if (display_q.size() != 0) begin
            failures += display_q.size();
            $display("%0t ns: displays never delivered, expected %0d more, actual 0",
                     $time, display_q.size());
        end
        $display("Run covered %0d words and %0d checked displays over %0d register writes.",
                 words_sent, displays_checked, reg_writes);
        $display("Percent band words %0d, odometer rollovers %0d, output hold of %0d cycles.",
                 pct_words, km_rollovers, hold_count);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
src/sobd_pkg.sv
src/sobd_battery.sv
src/sobd_speed.sv
src/sobd_odometer.sv
src/speed_odometer_battery_display_core.sv
tb/speed_odometer_battery_display_core_tb.sv
